>>> design/qtl_pkg.sv
// ----------------------------------------------------------------------------
// qtl_pkg
// Shared types and constants for the quoted token lexer.
// ----------------------------------------------------------------------------
package qtl_pkg;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Lexer state codes
    localparam logic [1:0] ST_SKIP   = 2'd0;
    localparam logic [1:0] ST_TOKEN  = 2'd1;
    localparam logic [1:0] ST_QUOTES = 2'd2;
    localparam logic [1:0] ST_ESCAPE = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_EMPTY        = 3'd1;
    localparam logic [2:0] ERR_NO_END_QUOTE = 3'd2;
    localparam logic [2:0] ERR_NO_ESCAPE    = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       token_done;
        logic [2:0] error_code;
    } out_item_t;

endpackage

>>> design/quoted_token_lexer_core.sv
// ----------------------------------------------------------------------------
// quoted_token_lexer_core
// Splits a byte stream into space-separated tokens with quoted sections.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | qtl_pkg::in_item_t  (char, end mark)
//  res     | out       | res_valid/res_stall | qtl_pkg::out_item_t (char, done, error)
//
//  One request per cycle sustained while res is not stalled; each request's
//  result reaches res through the input register, then the result register.
//  The lexer state advances as a request moves from the input register into
//  the result register, so back-to-back requests see each other's state.
//  Reset clears both valid flags and returns the lexer to skipping spaces.
//  A stall on res holds the result; req stalls only when both registers are
//  full and the result is not taken.
// ----------------------------------------------------------------------------
module quoted_token_lexer_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  qtl_pkg::in_item_t  req_data,
    output logic               res_valid,
    input  logic               res_stall,
    output qtl_pkg::out_item_t res_data
);

    logic               req_valid_reg;
    qtl_pkg::in_item_t  req_data_reg;
    logic               res_valid_reg;
    qtl_pkg::out_item_t res_data_reg;
    logic [1:0]         lex_state_reg;
    logic [1:0]         lex_state_next;
    qtl_pkg::out_item_t step_result;
    logic               advance;
    logic               load;

    assign advance   = req_valid_reg && (!res_valid_reg || !res_stall);
    assign load      = !req_valid_reg || advance;
    assign req_stall = !load;

    qtl_step u_step
    (
        .state      (lex_state_reg),
        .item       (req_data_reg),
        .result     (step_result),
        .state_next (lex_state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            lex_state_reg <= qtl_pkg::ST_SKIP;
        end
        else
        begin
            if (load)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                lex_state_reg <= lex_state_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            req_data_reg <= req_data;
        end
        if (advance)
        begin
            res_data_reg <= step_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> design/qtl_step.sv
// ----------------------------------------------------------------------------
// qtl_step
// One lexer step: current state and one request in, result and next state out.
// ----------------------------------------------------------------------------
module qtl_step
(
    input  logic [1:0]       state,
    input  qtl_pkg::in_item_t item,
    output qtl_pkg::out_item_t result,
    output logic [1:0]       state_next
);

    logic [7:0] c;
    logic       eoi;

    assign c   = item.char_in;
    assign eoi = item.end_of_input;

    always_comb
    begin
        result.char_out   = 8'h00;
        result.char_valid = 1'b0;
        result.token_done = 1'b0;
        result.error_code = qtl_pkg::ERR_NONE;
        state_next        = state;

        case (state)
            qtl_pkg::ST_SKIP:
            begin
                if (eoi)
                begin
                    result.error_code = qtl_pkg::ERR_EMPTY;
                end
                else if (c == qtl_pkg::CH_QUOTE)
                begin
                    state_next = qtl_pkg::ST_QUOTES;
                end
                else if (!(c inside {qtl_pkg::CH_SPACE, qtl_pkg::CH_BSLASH}))
                begin
                    result.char_out   = c;
                    result.char_valid = 1'b1;
                    state_next        = qtl_pkg::ST_TOKEN;
                end
            end
            qtl_pkg::ST_TOKEN:
            begin
                if (eoi || c == qtl_pkg::CH_SPACE)
                begin
                    result.token_done = 1'b1;
                    state_next        = qtl_pkg::ST_SKIP;
                end
                else if (c == qtl_pkg::CH_QUOTE)
                begin
                    state_next = qtl_pkg::ST_QUOTES;
                end
                else
                begin
                    result.char_out   = c;
                    result.char_valid = 1'b1;
                end
            end
            qtl_pkg::ST_QUOTES:
            begin
                if (eoi)
                begin
                    result.error_code = qtl_pkg::ERR_NO_END_QUOTE;
                    state_next        = qtl_pkg::ST_SKIP;
                end
                else if (c == qtl_pkg::CH_QUOTE)
                begin
                    result.token_done = 1'b1;
                    state_next        = qtl_pkg::ST_SKIP;
                end
                else if (c == qtl_pkg::CH_BSLASH)
                begin
                    state_next = qtl_pkg::ST_ESCAPE;
                end
                else
                begin
                    result.char_out   = c;
                    result.char_valid = 1'b1;
                end
            end
            qtl_pkg::ST_ESCAPE:
            begin
                if (eoi)
                begin
                    result.error_code = qtl_pkg::ERR_NO_ESCAPE;
                    state_next        = qtl_pkg::ST_SKIP;
                end
                else if (c inside {qtl_pkg::CH_QUOTE, qtl_pkg::CH_BSLASH})
                begin
                    result.char_out   = c;
                    result.char_valid = 1'b1;
                    state_next        = qtl_pkg::ST_QUOTES;
                end
                else
                begin
                    // keep the offending byte for the error report
                    result.char_out   = c;
                    result.error_code = qtl_pkg::ERR_BAD_ESCAPE;
                    state_next        = qtl_pkg::ST_SKIP;
                end
            end
            default:
            begin
                state_next = qtl_pkg::ST_SKIP;
            end
        endcase
    end

endmodule

>>> design/qtl_checker.sv
// ----------------------------------------------------------------------------
// qtl_checker
// Port-level checks on the quoted token lexer result stream.
// ----------------------------------------------------------------------------
module qtl_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  logic               res_stall,
    input  qtl_pkg::out_item_t res_data
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.error_code <= qtl_pkg::ERR_BAD_ESCAPE)
        else $error("error code out of range");

    // a token character never comes with an error or a token end
    a_char_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.char_valid |->
            res_data.error_code == qtl_pkg::ERR_NONE && !res_data.token_done)
        else $error("token character mixed with end or error");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.token_done |->
            res_data.error_code == qtl_pkg::ERR_NONE && res_data.char_out == 8'h00)
        else $error("token end carries error or character");

    // unused character slot is zero except on an illegal escape
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.char_valid &&
            res_data.error_code != qtl_pkg::ERR_BAD_ESCAPE |->
            res_data.char_out == 8'h00)
        else $error("unused character slot not zero");

endmodule

bind quoted_token_lexer_core qtl_checker u_qtl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

>>> tb/sv/quoted_token_lexer_core_test.sv
// ----------------------------------------------------------------------------
// quoted_token_lexer_core_test
// Self-checking bench for the quoted token lexer. Characters and end marks go
// in on the request channel. A scoreboard follows the lexer state, works out
// the result of every accepted request and checks the results in order. The
// bench runs a short directed sequence first, then random token phrases under
// changing idle and stall rates.
// ----------------------------------------------------------------------------
module quoted_token_lexer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    class token_scoreboard;
        logic [1:0]          lex_state;
        qtl_pkg::out_item_t  lexed_items[$];
        int                  errors;

        function new();
            lex_state = qtl_pkg::ST_SKIP;
            errors = 0;
        endfunction

        // Advance the lexer by one request and return the result it gives.
        function qtl_pkg::out_item_t lex_byte(qtl_pkg::in_item_t req);
            qtl_pkg::out_item_t res;
            logic [7:0]         c;
            logic               eoi;
            res = '0;
            res.error_code = qtl_pkg::ERR_NONE;
            c = req.char_in;
            eoi = req.end_of_input;
            case (lex_state)
                qtl_pkg::ST_SKIP:
                begin
                    if (eoi)
                        res.error_code = qtl_pkg::ERR_EMPTY;
                    else if (c == qtl_pkg::CH_QUOTE)
                        lex_state = qtl_pkg::ST_QUOTES;
                    else if (c != qtl_pkg::CH_SPACE && c != qtl_pkg::CH_BSLASH)
                    begin
                        res.char_out = c;
                        res.char_valid = 1'b1;
                        lex_state = qtl_pkg::ST_TOKEN;
                    end
                end
                qtl_pkg::ST_TOKEN:
                begin
                    if (eoi || c == qtl_pkg::CH_SPACE)
                    begin
                        res.token_done = 1'b1;
                        lex_state = qtl_pkg::ST_SKIP;
                    end
                    else if (c == qtl_pkg::CH_QUOTE)
                        lex_state = qtl_pkg::ST_QUOTES;
                    else
                    begin
                        res.char_out = c;
                        res.char_valid = 1'b1;
                    end
                end
                qtl_pkg::ST_QUOTES:
                begin
                    if (eoi)
                    begin
                        res.error_code = qtl_pkg::ERR_NO_END_QUOTE;
                        lex_state = qtl_pkg::ST_SKIP;
                    end
                    else if (c == qtl_pkg::CH_QUOTE)
                    begin
                        res.token_done = 1'b1;
                        lex_state = qtl_pkg::ST_SKIP;
                    end
                    else if (c == qtl_pkg::CH_BSLASH)
                        lex_state = qtl_pkg::ST_ESCAPE;
                    else
                    begin
                        res.char_out = c;
                        res.char_valid = 1'b1;
                    end
                end
                default:
                begin
                    if (eoi)
                    begin
                        res.error_code = qtl_pkg::ERR_NO_ESCAPE;
                        lex_state = qtl_pkg::ST_SKIP;
                    end
                    else if (c == qtl_pkg::CH_QUOTE || c == qtl_pkg::CH_BSLASH)
                    begin
                        res.char_out = c;
                        res.char_valid = 1'b1;
                        lex_state = qtl_pkg::ST_QUOTES;
                    end
                    else
                    begin
                        // keep the offending byte on an illegal escape
                        res.char_out = c;
                        res.error_code = qtl_pkg::ERR_BAD_ESCAPE;
                        lex_state = qtl_pkg::ST_SKIP;
                    end
                end
            endcase
            return res;
        endfunction

        function void note_request(qtl_pkg::in_item_t req);
            lexed_items.push_back(lex_byte(req));
        endfunction

        function void check_result(qtl_pkg::out_item_t got);
            qtl_pkg::out_item_t want;
            if (lexed_items.size() == 0)
            begin
                $error("unexpected result %h with nothing pending", got);
                errors++;
                return;
            end
            want = lexed_items.pop_front();
            if (got.char_out !== want.char_out)
            begin
                $error("char_out: expected %h, actual %h", want.char_out, got.char_out);
                errors++;
            end
            if (got.char_valid !== want.char_valid)
            begin
                $error("char_valid: expected %b, actual %b", want.char_valid, got.char_valid);
                errors++;
            end
            if (got.token_done !== want.token_done)
            begin
                $error("token_done: expected %b, actual %b", want.token_done, got.token_done);
                errors++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    qtl_pkg::in_item_t  req_data;
    logic               res_valid;
    logic               res_stall;
    qtl_pkg::out_item_t res_data;

    token_scoreboard sb = new();
    int send_idle_pct;
    int res_stall_pct;
    int items_sent;
    int cycle_count;

    quoted_token_lexer_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("quoted_token_lexer_core: mismatch");
        $finish;
    end

    // Drive the result stall at the falling edge, check at the rising edge.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            res_stall <= ($urandom_range(99) < res_stall_pct);
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check_result(res_data);
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(qtl_pkg::in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(item);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(logic [7:0] c);
        qtl_pkg::in_item_t item;
        item.char_in = c;
        item.end_of_input = 1'b0;
        send_request(item);
    endtask

    task automatic send_end();
        qtl_pkg::in_item_t item;
        // char is ignored here, but toggle it anyway
        item.char_in = 8'($urandom_range(255));
        item.end_of_input = 1'b1;
        send_request(item);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == qtl_pkg::CH_SPACE || b == qtl_pkg::CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == qtl_pkg::CH_QUOTE || b == qtl_pkg::CH_BSLASH);
        return b;
    endfunction

    task automatic send_noise();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            send_end();
        else if (r == 1)
            send_char(qtl_pkg::CH_SPACE);
        else if (r == 2)
            send_char(qtl_pkg::CH_QUOTE);
        else if (r == 3)
            send_char(qtl_pkg::CH_BSLASH);
        else
            send_char(8'($urandom_range(255)));
    endtask

    // Send one token phrase: leading spaces, plain and quoted segments, mostly a terminator; at times noise instead.
    task automatic send_phrase();
        int r;
        int nseg;
        r = $urandom_range(99);
        if (r < 15)
        begin
            repeat ($urandom_range(1, 4))
                send_noise();
            return;
        end
        repeat ($urandom_range(0, 2))
            send_char(qtl_pkg::CH_SPACE);
        nseg = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++)
        begin
            if ($urandom_range(1))
            begin
                repeat ($urandom_range(1, 4))
                    send_char(plain_byte());
            end
            else
            begin
                send_char(qtl_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        send_char(qtl_pkg::CH_BSLASH);
                        send_char($urandom_range(1) ? qtl_pkg::CH_QUOTE : qtl_pkg::CH_BSLASH);
                    end
                    else
                        send_char(quoted_byte());
                end
                // leave the quote open now and then
                if ($urandom_range(9) == 0)
                    break;
                send_char(qtl_pkg::CH_QUOTE);
            end
        end
        r = $urandom_range(9);
        if (r < 7)
            send_char(qtl_pkg::CH_SPACE);
        else if (r < 9)
            send_end();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        items_sent = 0;
        send_idle_pct = 27;
        res_stall_pct = 80;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty input, skipped backslash, extreme bytes, quoting and escapes
        send_end();
        send_char(qtl_pkg::CH_SPACE);
        send_char(qtl_pkg::CH_BSLASH);
        send_char(8'h00);
        send_char(qtl_pkg::CH_BSLASH);
        send_char(8'hFF);
        send_char(qtl_pkg::CH_QUOTE);
        send_char(qtl_pkg::CH_SPACE);
        send_char(qtl_pkg::CH_BSLASH);
        send_char(qtl_pkg::CH_QUOTE);
        send_char(qtl_pkg::CH_BSLASH);
        send_char(qtl_pkg::CH_BSLASH);
        send_char(qtl_pkg::CH_QUOTE);
        send_char("a");
        send_char(qtl_pkg::CH_SPACE);
        send_char(8'h80);
        send_end();
        send_char(qtl_pkg::CH_QUOTE);
        send_end();
        send_char(qtl_pkg::CH_QUOTE);
        send_char(qtl_pkg::CH_BSLASH);
        send_end();
        send_char(qtl_pkg::CH_QUOTE);
        send_char(qtl_pkg::CH_BSLASH);
        send_char("n");

        while (items_sent < 150)
            send_phrase();
        send_idle_pct = 80;
        res_stall_pct = 27;
        while (items_sent < 300)
            send_phrase();
        send_idle_pct = 0;
        res_stall_pct = 0;
        while (items_sent < 450)
            send_phrase();
        req_valid <= 1'b0;

        while (sb.lexed_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("quoted_token_lexer_core: match");
        else
            $display("quoted_token_lexer_core: mismatch");
        $finish;
    end

endmodule
